/* design/psfla_pkg.sv */
package psfla_pkg;

    localparam int POOL_SLOTS = 1024;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int COUNT_W    = 10;
    localparam int STATUS_W   = 2;

    localparam logic [SLOT_W-1:0]  SLOT_NONE = '0;
    localparam logic [SLOT_W-1:0]  HW_RESET  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]  HW_LIMIT  = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC   = 2'd0,
        ST_OOM     = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

endpackage

/* design/pool_slot_free_list_allocator_top.sv */
// Slot allocator for a pool of psfla_pkg::POOL_SLOTS slots; slot 0 means none.
// Every request runs through the idle and execute states: start is taken while busy is low, the link
// memory is read at that edge (head slot for allocate, given slot for free),
// and in the execute state the entry is updated; the result is then registered and presented for
// exactly one cycle with done high. busy is high in the execute state, so a new request
// can be taken again in the cycle in which done is high. The receiver cannot stall:
// done carries a result that must be taken in that cycle. No clearing pass is
// needed after reset; links are written before they are ever read.
module pool_slot_free_list_allocator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [psfla_pkg::SLOT_W-1:0]     slot_index,
    output logic                             done,
    output logic [psfla_pkg::SLOT_W-1:0]     granted_slot,
    output logic [psfla_pkg::STATUS_W-1:0]   status,
    output logic [psfla_pkg::COUNT_W-1:0]    active_count
);

    logic [psfla_pkg::SLOT_W-1:0] link_mem [psfla_pkg::POOL_SLOTS];
    logic [psfla_pkg::SLOT_W-1:0] rd_data_reg;
    logic [psfla_pkg::SLOT_W-1:0] rd_addr;

    psfla_pkg::fsm_t state_reg, state_next;

    logic                          act_reg;
    logic [psfla_pkg::SLOT_W-1:0]  idx_reg;

    logic [psfla_pkg::SLOT_W-1:0]  head_reg, head_next;
    logic [psfla_pkg::SLOT_W-1:0]  hw_reg, hw_next;
    logic [psfla_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                          done_reg;
    logic [psfla_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    psfla_pkg::status_t            status_reg, status_next;

    logic                          wr_en;
    logic [psfla_pkg::SLOT_W-1:0]  wr_addr;
    logic [psfla_pkg::SLOT_W-1:0]  wr_data;

    logic accept;

    assign accept  = start && (state_reg == psfla_pkg::S_IDLE);
    assign rd_addr = (action == psfla_pkg::ACT_FREE) ? slot_index : head_reg;

    always_comb
    begin
        unique case (state_reg)
            psfla_pkg::S_IDLE: state_next = accept ? psfla_pkg::S_EXEC : psfla_pkg::S_IDLE;
            psfla_pkg::S_EXEC: state_next = psfla_pkg::S_IDLE;
            default:           state_next = psfla_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg == psfla_pkg::S_EXEC);
    end

    // read-modify-write of the link memory in the execute state
    always_comb
    begin
        head_next   = head_reg;
        hw_next     = hw_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = head_reg;
        if (state_reg == psfla_pkg::S_EXEC)
        begin
            if (act_reg == psfla_pkg::ACT_ALLOC)
            begin
                if (head_reg != psfla_pkg::SLOT_NONE)
                begin
                    slot_next   = head_reg;
                    head_next   = rd_data_reg;
                    status_next = psfla_pkg::ST_ALLOC;
                    wr_en       = 1'b1;
                    wr_addr     = head_reg;
                    wr_data     = psfla_pkg::SLOT_NONE;
                end
                else if (hw_reg >= psfla_pkg::HW_LIMIT)
                begin
                    slot_next   = psfla_pkg::SLOT_NONE;
                    status_next = psfla_pkg::ST_OOM;
                end
                else
                begin
                    slot_next   = hw_reg;
                    hw_next     = hw_reg + psfla_pkg::SLOT_W'(1);
                    status_next = psfla_pkg::ST_ALLOC;
                    wr_en       = 1'b1;
                    wr_addr     = hw_reg;
                    wr_data     = psfla_pkg::SLOT_NONE;
                end
                if (status_next == psfla_pkg::ST_ALLOC && count_reg != psfla_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + psfla_pkg::COUNT_W'(1);
                end
            end
            else
            begin
                slot_next = psfla_pkg::SLOT_NONE;
                if (idx_reg == psfla_pkg::SLOT_NONE || idx_reg >= hw_reg
                    || rd_data_reg != psfla_pkg::SLOT_NONE)
                begin
                    status_next = psfla_pkg::ST_IGNORED;
                end
                else
                begin
                    status_next = psfla_pkg::ST_FREED;
                    head_next   = idx_reg;
                    wr_en       = 1'b1;
                    wr_addr     = idx_reg;
                    wr_data     = head_reg;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - psfla_pkg::COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            idx_reg <= slot_index;
        end
        slot_reg   <= slot_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psfla_pkg::S_IDLE;
            head_reg  <= psfla_pkg::SLOT_NONE;
            hw_reg    <= psfla_pkg::HW_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            hw_reg    <= hw_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == psfla_pkg::S_EXEC);
        end
    end

    assign done         = done_reg;
    assign granted_slot = slot_reg;
    assign status       = status_reg;
    assign active_count = count_reg;

endmodule
